// ===== design/c8ic_pkg.sv =====
package c8ic_pkg;

  localparam int MemBytes   = 4096;
  localparam int ScreenW    = 64;
  localparam int ScreenH    = 32;
  localparam int StackDepth = 16;
  localparam int FontBytes  = 80;

  localparam logic [11:0] RESET_PC = 12'd512;

  localparam logic [2:0] KIND_EXEC      = 3'd0;
  localparam logic [2:0] KIND_WRITE_MEM = 3'd1;
  localparam logic [2:0] KIND_READ_MEM  = 3'd2;
  localparam logic [2:0] KIND_READ_REG  = 3'd3;
  localparam logic [2:0] KIND_READ_PIX  = 3'd4;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
  localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SEV  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNEV = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] F_GET_DT = 8'h07;
  localparam logic [7:0] F_SET_DT = 8'h15;
  localparam logic [7:0] F_SET_ST = 8'h18;
  localparam logic [7:0] F_ADD_I  = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STORE  = 8'h55;
  localparam logic [7:0] F_LOAD   = 8'h65;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RX, S_RY, S_EXEC, S_FLAG, S_CLR,
    S_DRD, S_DWR, S_BCD, S_MRD, S_MWR, S_FIN
  } state_t;

  typedef struct packed {
    logic       we;
    logic [7:0] res;
    logic       fwe;
    logic [7:0] flag;
  } alu_res_t;

  localparam logic [0:FontBytes-1][7:0] FONT_ROM = {
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [6:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (i < 7'(FontBytes)) b = FONT_ROM[i];
    return b;
  endfunction

  // hundreds, tens, ones of a byte
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    h = 2'd0;
    r = v;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 8'(t) * 8'd10;
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage

// ===== design/chip8_instruction_core_top.sv =====
// chip-8 instruction core: one item is an instruction to execute, a memory write, or a
// read of memory, a data register or a display pixel, and each item gives exactly one
// result carrying the pc, index, vf, timers and a stack fault code. memory (4 kb), the
// display rows (32 x 64 bits) and v0..vf live in three synchronous rams with registered
// read data; the sequencer reads vx and vy one after the other, then modifies and
// writes back. after reset a pass loads the font into bytes 0..79, clears the display
// and the data registers; no item is taken during it, configuration writes are. a flag
// write to vf takes a step of its own; 00e0 clears every row, dxyn reads and writes each
// sprite row and then the flag, fx33 writes three digits, and fx55/fx65 move each
// register in turn. an item waits in the finish state while an earlier result is still
// held by out_stall. writing boot_pc loads the pc at once.
module chip8_instruction_core_top
  import c8ic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] boot_pc,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] opcode,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [11:0] program_counter,
  output logic [15:0] index_value,
  output logic [7:0]  flag_register,
  output logic [7:0]  delay_value,
  output logic [7:0]  sound_value,
  output logic [1:0]  fault
);

  state_t state, state_next;

  // latched item
  logic [2:0]  kind_q;
  logic [15:0] op_q;
  logic [11:0] addr_q;
  logic [7:0]  data_q;
  logic [7:0]  rnd_q;

  // architectural state held in flops
  logic [11:0] pc;
  logic [15:0] idx;
  logic [7:0]  vf;
  logic [7:0]  dly;
  logic [7:0]  snd;
  logic [3:0]  sp;
  logic [11:0] stack [StackDepth];

  // working registers
  logic [6:0] cnt;
  logic [7:0] vx_q;
  logic [7:0] vy_q;
  logic [7:0] flag_q;
  logic       hit;
  logic [1:0] fault_q;
  logic [7:0] rd_q;
  logic [2:0] out_kind;

  // ram ports
  logic        m_we, f_we, v_we;
  logic [11:0] m_waddr, m_raddr;
  logic [7:0]  m_wdata, m_rdata;
  logic [4:0]  f_waddr, f_raddr;
  logic [63:0] f_wdata, f_rdata;
  logic [3:0]  v_waddr, v_raddr;
  logic [7:0]  v_wdata, v_rdata;

  c8ic_ram #(.WIDTH(8), .DEPTH(MemBytes)) u_mem (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );
  c8ic_ram #(.WIDTH(ScreenW), .DEPTH(ScreenH)) u_frame (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );
  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );

  // opcode fields
  logic [3:0]  grp, ox, oy, on;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign grp = op_q[15:12];
  assign ox  = op_q[11:8];
  assign oy  = op_q[7:4];
  assign on  = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];

  alu_res_t alu;
  c8ic_alu u_alu (.sel(on), .vx(vx_q), .vy(v_rdata), .o(alu));

  // execute decode, valid in S_EXEC where v_rdata holds vy (or v0 for bnnn)
  logic [11:0] pc2;
  logic        ex_vwe;
  logic [7:0]  ex_vres;
  logic        ex_fwe;
  logic [7:0]  ex_flag;
  logic [16:0] idx_sum;
  logic [11:0] bcd;
  logic        f_store, f_load;

  assign pc2     = pc + 12'd2;
  assign idx_sum = {1'b0, idx} + 17'(vx_q);
  assign bcd     = bcd_digits(vx_q);
  assign f_store = (grp == GRP_MISC) && (kk == F_STORE);
  assign f_load  = (grp == GRP_MISC) && (kk == F_LOAD);

  always_comb begin
    ex_vwe  = 1'b0;
    ex_vres = 8'd0;
    ex_fwe  = 1'b0;
    ex_flag = 8'd0;
    unique case (grp)
      GRP_LD:  begin ex_vwe = 1'b1; ex_vres = kk; end
      GRP_ADD: begin ex_vwe = 1'b1; ex_vres = vx_q + kk; end
      GRP_ALU: begin
        ex_vwe = alu.we; ex_vres = alu.res; ex_fwe = alu.fwe; ex_flag = alu.flag;
      end
      GRP_RND: begin ex_vwe = 1'b1; ex_vres = rnd_q & kk; end
      GRP_MISC: begin
        if (kk == F_GET_DT) begin
          ex_vwe = 1'b1; ex_vres = dly;
        end
        if (kk == F_ADD_I) begin
          ex_fwe = 1'b1; ex_flag = {7'd0, |idx_sum[16:12]};
        end
      end
      default: ;
    endcase
  end

  // sprite row mask, rotated so that wrapping columns fall at the left edge
  logic [63:0] spr, spr_rot;
  logic [7:0]  line_rev;
  always_comb begin
    for (int b = 0; b < 8; b++) line_rev[b] = m_rdata[7-b];
  end
  assign spr     = {56'd0, line_rev};
  assign spr_rot = (spr << vx_q[5:0]) | (spr >> (7'd64 - {1'b0, vx_q[5:0]}));

  logic last_row, last_reg, hit_now;
  assign last_row = (cnt[3:0] + 4'd1) == on;
  assign last_reg = cnt[3:0] == ox;
  assign hit_now  = hit | (|(f_rdata & spr_rot));

  logic fin_ok;
  assign fin_ok = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (cnt == 7'(FontBytes - 1)) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_RX;
      S_RX:   state_next = S_RY;
      S_RY:   state_next = (kind_q == KIND_EXEC) ? S_EXEC : S_FIN;
      S_EXEC: begin
        state_next = S_FIN;
        if (op_q == OP_CLS) state_next = S_CLR;
        else if (grp == GRP_DRW) state_next = (on == 4'd0) ? S_FLAG : S_DRD;
        else if (grp == GRP_MISC && kk == F_BCD) state_next = S_BCD;
        else if (f_store || f_load) state_next = S_MRD;
        else if (ex_fwe) state_next = S_FLAG;
      end
      S_FLAG: state_next = S_FIN;
      S_CLR:  if (cnt[4:0] == 5'(ScreenH - 1)) state_next = S_FIN;
      S_DRD:  state_next = S_DWR;
      S_DWR:  state_next = last_row ? S_FLAG : S_DRD;
      S_BCD:  if (cnt[1:0] == 2'd2) state_next = S_FIN;
      S_MRD:  state_next = S_MWR;
      S_MWR:  state_next = last_reg ? S_FIN : S_MRD;
      S_FIN:  if (fin_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ram ports and handshakes
  always_comb begin
    in_stall  = (state != S_IDLE);
    cfg_ready = 1'b1;
    m_we = 1'b0; m_waddr = addr_q; m_wdata = data_q; m_raddr = addr_q;
    f_we = 1'b0; f_waddr = vy_q[4:0] + cnt[4:0]; f_wdata = '0; f_raddr = addr_q[10:6];
    v_we = 1'b0; v_waddr = ox; v_wdata = ex_vres; v_raddr = ox;
    unique case (state)
      S_INIT: begin
        m_we = 1'b1; m_waddr = 12'(cnt); m_wdata = font_byte(cnt);
        f_we = cnt < 7'(ScreenH); f_waddr = cnt[4:0];
        v_we = cnt < 7'd16; v_waddr = cnt[3:0]; v_wdata = 8'd0;
      end
      S_RX: begin
        m_we = (kind_q == KIND_WRITE_MEM);
        v_raddr = (kind_q == KIND_READ_REG) ? addr_q[3:0] : ox;
      end
      S_RY:   v_raddr = (grp == GRP_JPV) ? 4'd0 : oy;
      S_EXEC: v_we = ex_vwe;
      S_FLAG: begin v_we = 1'b1; v_waddr = 4'd15; v_wdata = flag_q; end
      S_CLR:  begin f_we = 1'b1; f_waddr = cnt[4:0]; end
      S_DRD: begin
        m_raddr = idx[11:0] + 12'(cnt);
        f_raddr = vy_q[4:0] + cnt[4:0];
      end
      S_DWR:  begin f_we = 1'b1; f_wdata = f_rdata ^ spr_rot; end
      S_BCD: begin
        m_we = 1'b1; m_waddr = idx[11:0] + 12'(cnt);
        case (cnt[1:0])
          2'd0:    m_wdata = {4'd0, bcd[11:8]};
          2'd1:    m_wdata = {4'd0, bcd[7:4]};
          default: m_wdata = {4'd0, bcd[3:0]};
        endcase
      end
      S_MRD: begin
        v_raddr = cnt[3:0];
        m_raddr = idx[11:0] + 12'(cnt);
      end
      S_MWR: begin
        m_we = f_store; m_waddr = idx[11:0] + 12'(cnt); m_wdata = v_rdata;
        v_we = f_load; v_waddr = cnt[3:0]; v_wdata = m_rdata;
      end
      default: ;
    endcase
  end

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      pc        <= RESET_PC;
      idx       <= '0;
      vf        <= '0;
      dly       <= '0;
      snd       <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
      out_kind  <= KIND_EXEC;
    end else begin
      state <= state_next;
      if (v_we && v_waddr == 4'd15) vf <= v_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_INIT: cnt <= cnt + 7'd1;
        S_IDLE: if (in_valid) begin
          kind_q  <= kind;
          op_q    <= opcode;
          addr_q  <= address;
          data_q  <= data;
          rnd_q   <= random_byte;
          fault_q <= FAULT_NONE;
          rd_q    <= 8'd0;
        end
        S_RY: begin
          vx_q <= v_rdata;
          case (kind_q)
            KIND_READ_MEM: rd_q <= m_rdata;
            KIND_READ_REG: rd_q <= (addr_q[11:4] == 8'd0) ? v_rdata : 8'd0;
            KIND_READ_PIX: rd_q <= {7'd0, !addr_q[11] && f_rdata[addr_q[5:0]]};
            default:       rd_q <= 8'd0;
          endcase
        end
        S_EXEC: begin
          vy_q   <= v_rdata;
          cnt    <= '0;
          hit    <= 1'b0;
          flag_q <= ex_flag;
          pc     <= pc2;
          unique case (grp)
            GRP_SYS: if (op_q == OP_RET) begin
              if (sp == 4'd0) fault_q <= FAULT_UNDERFLOW;
              else begin
                sp <= sp - 4'd1;
                pc <= stack[sp - 4'd1];
              end
            end
            GRP_JP: pc <= nnn;
            GRP_CALL: begin
              if (sp == 4'(StackDepth - 1)) fault_q <= FAULT_OVERFLOW;
              else begin
                stack[sp] <= pc2;
                sp <= sp + 4'd1;
                pc <= nnn;
              end
            end
            GRP_SE:   if (vx_q == kk) pc <= pc2 + 12'd2;
            GRP_SNE:  if (vx_q != kk) pc <= pc2 + 12'd2;
            GRP_SEV:  if (vx_q == v_rdata) pc <= pc2 + 12'd2;
            GRP_SNEV: if (vx_q != v_rdata) pc <= pc2 + 12'd2;
            GRP_LDI:  idx <= {4'd0, nnn};
            GRP_JPV:  pc <= nnn + 12'(v_rdata);
            GRP_MISC: begin
              case (kk)
                F_SET_DT: dly <= vx_q;
                F_SET_ST: snd <= vx_q;
                F_ADD_I:  idx <= idx_sum[15:0];
                F_FONT:   idx <= {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_CLR: cnt <= cnt + 7'd1;
        S_DWR: begin
          hit    <= hit_now;
          flag_q <= {7'd0, hit_now};
          cnt    <= cnt + 7'd1;
        end
        S_BCD: cnt <= cnt + 7'd1;
        S_MWR: begin
          cnt <= cnt + 7'd1;
          if (last_reg) idx <= idx + 16'(ox) + 16'd1;
        end
        S_FIN: if (fin_ok) begin
          out_valid       <= 1'b1;
          out_kind        <= kind_q;
          read_data       <= rd_q;
          program_counter <= pc;
          index_value     <= idx;
          flag_register   <= vf;
          delay_value     <= dly;
          sound_value     <= snd;
          fault           <= fault_q;
        end
        default: ;
      endcase
      if (cfg_valid && cfg_ready) pc <= boot_pc;
    end
  end

  // a stack fault only comes from an executed instruction
  a_fault_exec: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault != FAULT_NONE |-> out_kind == KIND_EXEC)
    else $error("fault on a non-execute item");

  // only the read kinds return data
  a_read_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != 8'd0 |->
      out_kind == KIND_READ_MEM || out_kind == KIND_READ_REG || out_kind == KIND_READ_PIX)
    else $error("read data on a non-read item");

  // a result is loaded only from the finish state
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside finish");

  // nothing is taken during the font load
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> in_stall && !out_valid)
    else $error("activity during initial load");

endmodule

// ===== design/c8ic_ram.sv =====
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/c8ic_alu.sv =====
module c8ic_alu
  import c8ic_pkg::*;
(
  input  logic [3:0] sel,
  input  logic [7:0] vx,
  input  logic [7:0] vy,
  output alu_res_t   o
);

  logic [8:0] sum;

  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    o = '0;
    case (sel)
      ALU_MOV: begin o.we = 1'b1; o.res = vy; end
      ALU_OR:  begin o.we = 1'b1; o.res = vx | vy; end
      ALU_AND: begin o.we = 1'b1; o.res = vx & vy; end
      ALU_XOR: begin o.we = 1'b1; o.res = vx ^ vy; end
      ALU_ADD: begin
        o.we = 1'b1; o.res = sum[7:0]; o.fwe = 1'b1; o.flag = {7'd0, sum[8]};
      end
      ALU_SUB: begin
        o.we = 1'b1; o.res = vx - vy; o.fwe = 1'b1; o.flag = {7'd0, vx > vy};
      end
      ALU_SHR: begin
        o.we = 1'b1; o.res = {1'b0, vx[7:1]}; o.fwe = 1'b1; o.flag = {7'd0, vx[0]};
      end
      ALU_SBN: begin
        o.we = 1'b1; o.res = vy - vx; o.fwe = 1'b1; o.flag = {7'd0, vy > vx};
      end
      ALU_SHL: begin
        o.we = 1'b1; o.res = {vx[6:0], 1'b0}; o.fwe = 1'b1; o.flag = {7'd0, vx[7]};
      end
      default: o = '0;
    endcase
  end

endmodule
